/* hw/rtl/lifo_stack_search_replace_macros.svh */
// ----------------------------------------------------------------------------
// lifo stack search/replace assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_SEARCH_REPLACE_MACROS_SVH
`define LIFO_STACK_SEARCH_REPLACE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LSSR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define LSSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LSSR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LSSR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/lssr_pkg.sv */
// ----------------------------------------------------------------------------
// lifo stack search/replace package
// request modes, result status codes and sequencer states
// ----------------------------------------------------------------------------
package lssr_pkg;

  // request modes
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_MODIFY = 2'd1;
  localparam logic [1:0] MODE_DRAIN  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

/* hw/rtl/lifo_stack_search_replace.sv */
// ----------------------------------------------------------------------------
// lifo stack with search/replace
// push: result in the cycle after the transaction, busy stays low (one per cycle);
// modify or drain on an empty stack answers the same way.
// modify: after a fetch state, entries are compared top first, at most DEPTH of them,
// busy in the fetch and scan states; one entry per cycle through the single compare unit.
// drain of n entries: after a fetch state, n results follow, one per cycle, with
// busy high in the fetch and drain states. The receiver cannot stall results. Sync rst
// clears the entry count, sequencer and strobe; store contents are not cleared.
// ----------------------------------------------------------------------------
`include "lifo_stack_search_replace_macros.svh"

module lifo_stack_search_replace #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [31:0] value,
  input  logic signed [31:0] new_value,
  output logic               strobe,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic               last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // stack store and read port
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_data;

  // control state
  lssr_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [1:0]       op;
  logic signed [31:0] key;
  logic signed [31:0] nval;

  // result registers
  logic               strobe_next;
  logic [1:0]         status_next;
  logic signed [31:0] data_next;
  logic               last_next;

  // decoded conditions
  logic             acc;
  logic             full;
  logic             empty;
  logic             match;
  logic             ptr_zero;
  logic [CNT_W-1:0] count_m1;

  assign busy     = (state != lssr_pkg::ST_IDLE);
  assign acc      = start && !busy;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign match    = (rd_data == key);
  assign ptr_zero = (ptr == '0);
  assign count_m1 = count - CNT_W'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lssr_pkg::ST_IDLE: begin
        if (acc && !empty && (mode == lssr_pkg::MODE_MODIFY ||
                              mode == lssr_pkg::MODE_DRAIN)) begin
          state_next = lssr_pkg::ST_FETCH;
        end
      end
      lssr_pkg::ST_FETCH: begin
        state_next = (op == lssr_pkg::MODE_MODIFY) ? lssr_pkg::ST_SCAN
                                                   : lssr_pkg::ST_DRAIN;
      end
      lssr_pkg::ST_SCAN: begin
        if (match || ptr_zero) begin
          state_next = lssr_pkg::ST_IDLE;
        end
      end
      lssr_pkg::ST_DRAIN: begin
        if (ptr_zero) begin
          state_next = lssr_pkg::ST_IDLE;
        end
      end
      default: state_next = lssr_pkg::ST_IDLE;
    endcase
  end

  // datapath control and result values
  always_comb begin
    count_next  = count;
    ptr_next    = ptr;
    wr_en       = 1'b0;
    wr_addr     = count[IDX_W-1:0];
    wr_data     = value;
    rd_addr     = ptr - IDX_W'(1);
    strobe_next = 1'b0;
    status_next = lssr_pkg::STATUS_DONE;
    data_next   = '0;
    last_next   = 1'b1;
    unique case (state)
      lssr_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (mode)
            lssr_pkg::MODE_PUSH: begin
              strobe_next = 1'b1;
              if (full) begin
                status_next = lssr_pkg::STATUS_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            lssr_pkg::MODE_MODIFY, lssr_pkg::MODE_DRAIN: begin
              if (empty) begin
                strobe_next = 1'b1;
                status_next = lssr_pkg::STATUS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      lssr_pkg::ST_FETCH: begin
        rd_addr  = count_m1[IDX_W-1:0];
        ptr_next = count_m1[IDX_W-1:0];
      end
      lssr_pkg::ST_SCAN: begin
        // compare the entry read last cycle, fetch the one below
        if (match) begin
          wr_en       = 1'b1;
          wr_addr     = ptr;
          wr_data     = nval;
          strobe_next = 1'b1;
          data_next   = rd_data;
        end else if (ptr_zero) begin
          strobe_next = 1'b1;
          status_next = lssr_pkg::STATUS_NOTFOUND;
        end else begin
          ptr_next = ptr - IDX_W'(1);
        end
      end
      lssr_pkg::ST_DRAIN: begin
        // pop one entry a cycle, top first
        strobe_next = 1'b1;
        data_next   = rd_data;
        last_next   = ptr_zero;
        count_next  = CNT_W'(ptr);
        if (!ptr_zero) begin
          ptr_next = ptr - IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lssr_pkg::ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    status <= status_next;
    data   <= data_next;
    last   <= last_next;
    if (acc) begin
      op   <= mode;
      key  <= value;
      nval <= new_value;
    end
  end

  // assertions
  `LSSR_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `LSSR_ASSERT_IMPLY(a_notlast_is_drain, clk, rst, strobe && !last,
                     status == lssr_pkg::STATUS_DONE && state == lssr_pkg::ST_DRAIN)
  `LSSR_ASSERT_NEXT(a_push_done, clk, rst,
                    acc && mode == lssr_pkg::MODE_PUSH && !full,
                    strobe && status == lssr_pkg::STATUS_DONE &&
                    count == $past(count) + CNT_W'(1))
  `LSSR_ASSERT_IMPLY(a_drain_clears, clk, rst,
                     state == lssr_pkg::ST_IDLE && $past(state) == lssr_pkg::ST_DRAIN,
                     count == '0 && strobe && last)

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// lifo stack search/replace testbench
// drives push, search-and-replace and drain transactions into the stack,
// predicts every result from a private copy of the stack, and checks each
// strobed result field by field in arrival order
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = 16;
  localparam int LIMIT_CYCLES = 200000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
  localparam logic signed [31:0] BOTTOM_KEY = 32'sh5a5a5a5a;
  localparam logic signed [31:0] DUP_KEY = 32'sd7;
  localparam logic signed [31:0] ABSENT_KEY = 32'sh13572468;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         mode;
  logic signed [31:0] value;
  logic signed [31:0] new_value;
  logic               strobe;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic               last;

  // predicted stack contents and pending results
  logic signed [31:0] shadow_stack [DEPTH];
  int                 shadow_count;
  result_t            pending_results [$];

  int  n_errors;
  int  n_requests;
  int  n_results;
  int  n_full;
  int  n_notfound;
  int  n_cycles = 0;
  bit  gaps_on;

  lifo_stack_search_replace #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .value(value),
    .new_value(new_value),
    .strobe(strobe),
    .status(status),
    .data(data),
    .last(last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void add_result(logic [1:0] st, logic signed [31:0] d, logic l);
    result_t r;
    r.status = st;
    r.data = d;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  // stack predictor: updates the shadow stack and queues the results
  function automatic void apply_request(logic [1:0] m, logic signed [31:0] v,
                                        logic signed [31:0] nv);
    int  i;
    bit  found;
    found = 1'b0;
    case (m)
      lssr_pkg::MODE_PUSH: begin
        if (shadow_count >= DEPTH) begin
          add_result(lssr_pkg::STATUS_FULL, 32'sd0, 1'b1);
          n_full++;
        end else begin
          shadow_stack[shadow_count] = v;
          shadow_count++;
          add_result(lssr_pkg::STATUS_DONE, 32'sd0, 1'b1);
        end
      end
      lssr_pkg::MODE_MODIFY: begin
        if (shadow_count == 0) begin
          add_result(lssr_pkg::STATUS_EMPTY, 32'sd0, 1'b1);
        end else begin
          // topmost match wins
          for (i = shadow_count - 1; i >= 0 && !found; i--) begin
            if (shadow_stack[i] == v) begin
              add_result(lssr_pkg::STATUS_DONE, shadow_stack[i], 1'b1);
              shadow_stack[i] = nv;
              found = 1'b1;
            end
          end
          if (!found) begin
            add_result(lssr_pkg::STATUS_NOTFOUND, 32'sd0, 1'b1);
            n_notfound++;
          end
        end
      end
      lssr_pkg::MODE_DRAIN: begin
        if (shadow_count == 0) begin
          add_result(lssr_pkg::STATUS_EMPTY, 32'sd0, 1'b1);
        end else begin
          while (shadow_count > 0) begin
            shadow_count--;
            add_result(lssr_pkg::STATUS_DONE, shadow_stack[shadow_count],
                       shadow_count == 0);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // result checker, one strobed result per cycle at most
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending: status %0d data %0d last %0d",
               status, data, last);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          n_errors++;
        end
        if (data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, data);
          n_errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          n_errors++;
        end
      end
    end
  end

  // drive one transaction and hold it until accepted; start stays high
  task automatic send_request(logic [1:0] m, logic signed [31:0] v,
                              logic signed [31:0] nv);
    start <= 1'b1;
    mode <= m;
    value <= v;
    new_value <= nv;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_request(m, v, nv);
    if (m != MODE_UNUSED) n_requests++;
  endtask

  // random idle burst on the sender side
  task automatic maybe_idle();
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // hold off until every pending result has come back
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // key taken from the stack most of the time, so searches mostly hit
  function automatic logic signed [31:0] pick_key();
    if (shadow_count > 0 && $urandom_range(0, 9) < 7)
      return shadow_stack[$urandom_range(0, shadow_count - 1)];
    return pick_value();
  endfunction

  task automatic test_empty_requests();
    send_request(lssr_pkg::MODE_MODIFY, 32'sd5, 32'sd6);
    send_request(lssr_pkg::MODE_DRAIN, 32'sd0, 32'sd0);
    send_request(MODE_UNUSED, -32'sd1, -32'sd1);
  endtask

  // fill to the top with extremes and repeated keys, then overflow
  task automatic test_fill_to_overflow();
    logic signed [31:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) v = BOTTOM_KEY;
      else if (i == 1) v = VAL_MAX;
      else if (i == 2) v = VAL_MIN;
      else if (i == 3) v = 32'sd0;
      else if (i == 4) v = -32'sd1;
      else if (i % 5 == 0) v = DUP_KEY;
      else v = $urandom;
      send_request(lssr_pkg::MODE_PUSH, v, 32'sd0);
    end
    send_request(lssr_pkg::MODE_PUSH, 32'sd123, 32'sd0);
  endtask

  task automatic test_search_replace();
    send_request(lssr_pkg::MODE_MODIFY, DUP_KEY, VAL_MAX);
    send_request(lssr_pkg::MODE_MODIFY, DUP_KEY, VAL_MIN);
    send_request(lssr_pkg::MODE_MODIFY, BOTTOM_KEY, -32'sd1);
    send_request(lssr_pkg::MODE_MODIFY, ABSENT_KEY, 32'sd0);
  endtask

  task automatic test_drain_full();
    send_request(lssr_pkg::MODE_DRAIN, $urandom, $urandom);
  endtask

  // one burst of mostly pushes (with stray searches and unused modes), then some searches, maybe a drain
  task automatic run_episode(ref int count);
    int run_len;
    run_len = $urandom_range(0, DEPTH + 2);
    for (int i = 0; i < run_len; i++) begin
      maybe_idle();
      case ($urandom_range(0, 9))
        0: send_request(MODE_UNUSED, $urandom, $urandom);
        1: begin
          send_request(lssr_pkg::MODE_MODIFY, $urandom, $urandom);
          count++;
        end
        default: begin
          send_request(lssr_pkg::MODE_PUSH, pick_value(), $urandom);
          count++;
        end
      endcase
    end
    repeat ($urandom_range(1, 6)) begin
      maybe_idle();
      send_request(lssr_pkg::MODE_MODIFY, pick_key(), pick_value());
      count++;
    end
    if ($urandom_range(0, 1) == 0) begin
      maybe_idle();
      send_request(lssr_pkg::MODE_DRAIN, $urandom, $urandom);
      count++;
    end
  endtask

  task automatic test_random_traffic(int target);
    int  count;
    bit  paused;
    count = 0;
    paused = 1'b0;
    while (count < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      run_episode(count);
      if (!paused && count >= target / 2) begin
        wait_quiet();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_back_to_back(int target);
    int count;
    count = 0;
    gaps_on = 1'b0;
    while (count < target) run_episode(count);
  endtask

  // main sequence
  initial begin
    n_errors = 0;
    n_requests = 0;
    n_results = 0;
    n_full = 0;
    n_notfound = 0;
    shadow_count = 0;
    gaps_on = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= lssr_pkg::MODE_PUSH;
    value <= 32'sd0;
    new_value <= 32'sd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_requests();
    test_fill_to_overflow();
    test_search_replace();
    test_drain_full();
    test_random_traffic(180);
    test_back_to_back(40);

    // let the last transaction finish and catch any stray result
    wait_quiet();
    repeat (DEPTH + 4) @(posedge clk);

    $display("ran %0d requests with %0d results checked", n_requests, n_results);
    $display("overflowed pushes: %0d, searches that missed: %0d", n_full, n_notfound);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_errors,
               pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lssr_pkg.sv
hw/rtl/lifo_stack_search_replace.sv
tb/sv/tb_top.sv
